[hw/rtl/bb3_pkg.sv]
// Shared types and constants for the 3x3 RGB box blur.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package bb3_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int ADDR_W     = $clog2(MAX_WIDTH);
  localparam int COL_W      = 11;
  localparam int ROW_W      = 16;
  localparam int CHAN_W     = 8;
  localparam int NUM_CH     = 3;
  localparam int WIDTH_W    = 12;
  localparam int HEIGHT_W   = 16;
  localparam int CFG_DATA_W = 16;
  localparam int NUM_TAPS   = 9;
  localparam int SUM_W      = 12;

  // Division by nine as a multiply by ceil(2^14 / 9) and a shift; exact for sums up to 2295.
  localparam int RECIP_W     = 11;
  localparam int RECIP_SHIFT = 14;
  localparam int PROD_W      = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP9 = RECIP_W'(1821);

  localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(640);
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(480);
  localparam logic [WIDTH_W-1:0]  WIDTH_MIN    = WIDTH_W'(3);
  localparam logic [WIDTH_W-1:0]  WIDTH_MAX    = WIDTH_W'(MAX_WIDTH);
  localparam logic [HEIGHT_W-1:0] HEIGHT_MIN   = HEIGHT_W'(3);

  typedef enum logic {
    CFG_IMAGE_WIDTH  = 1'b0,
    CFG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_e;

  // Index 2 is red, 1 is green, 0 is blue.
  typedef logic [NUM_CH-1:0][CHAN_W-1:0] pixel_t;
  typedef logic [NUM_CH-1:0][SUM_W-1:0]  sums_t;
  typedef logic [2*NUM_CH*CHAN_W-1:0]    line_word_t;

  typedef struct packed {
    logic             emit;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
  } pos_t;

endpackage

`default_nettype wire

[hw/rtl/box_blur_3x3_rgb_unit.sv]
// 3x3 box blur on an RGB raster stream: top level with position counters and frame registers.
// Instantiates bb3_line_buf, bb3_window and bb3_div9; uses bb3_pkg.
//
// The unit takes one pixel per clock in raster order unless the output stalls and, for every
// interior pixel, delivers the truncated mean of its 3x3 neighborhood of original pixels once the
// pixel below and to the right has been transferred; border pixels produce nothing. Each result
// passes the pixel, sum and output registers. The rate is set by the line store, a single RAM of
// 2048 entries by 48 bits holding the two previous rows, which is read once and written once per
// pixel; a back-to-back access to the same entry is served by a bypass. The RAM needs no clearing
// after reset, so pixels are taken from the first cycle. Frame size is written through the
// configuration port while the unit is idle; frame_start forces the current pixel to column 0, row 0.
`default_nettype none

module box_blur_3x3_rgb_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic                              cfg_idx_i,
  input  logic [bb3_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [bb3_pkg::CHAN_W-1:0]        red_in_i,
  input  logic [bb3_pkg::CHAN_W-1:0]        green_in_i,
  input  logic [bb3_pkg::CHAN_W-1:0]        blue_in_i,
  input  logic                              frame_start_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [bb3_pkg::CHAN_W-1:0]        red_out_o,
  output logic [bb3_pkg::CHAN_W-1:0]        green_out_o,
  output logic [bb3_pkg::CHAN_W-1:0]        blue_out_o,
  output logic [bb3_pkg::COL_W-1:0]         center_column_o,
  output logic [bb3_pkg::ROW_W-1:0]         center_row_o
);

  logic [bb3_pkg::WIDTH_W-1:0]  width_q, width_d;
  logic [bb3_pkg::HEIGHT_W-1:0] height_q, height_d;
  logic [bb3_pkg::WIDTH_W-1:0]  eff_width;
  logic [bb3_pkg::HEIGHT_W-1:0] eff_height;

  logic [bb3_pkg::COL_W-1:0]    col_q, col_d, col_cur;
  logic [bb3_pkg::ROW_W-1:0]    row_q, row_d, row_cur;
  logic                         col_last;
  logic                         row_last;

  logic                         in_xfer;
  logic                         s1_valid_q, s1_valid_d;
  bb3_pkg::pos_t                s1_pos_q, s1_pos_d;
  bb3_pkg::pixel_t              s1_cur_q, in_pix;
  logic [bb3_pkg::ADDR_W-1:0]   s1_addr_q;
  logic                         s1_adv;

  bb3_pkg::line_word_t          rd_word;
  bb3_pkg::pixel_t              top_pix, mid_pix;

  logic                         s2_valid;
  bb3_pkg::pos_t                s2_pos;
  bb3_pkg::sums_t               s2_sums;
  logic                         s2_ready;
  bb3_pkg::pixel_t              out_pix;
  bb3_pkg::pos_t                out_pos;

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (cfg_we_i) begin
      unique case (bb3_pkg::cfg_reg_e'(cfg_idx_i))
        bb3_pkg::CFG_IMAGE_WIDTH:  width_d  = cfg_wdata_i[bb3_pkg::WIDTH_W-1:0];
        bb3_pkg::CFG_IMAGE_HEIGHT: height_d = cfg_wdata_i[bb3_pkg::HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_q < bb3_pkg::WIDTH_MIN) begin
      eff_width = bb3_pkg::WIDTH_MIN;
    end else if (width_q > bb3_pkg::WIDTH_MAX) begin
      eff_width = bb3_pkg::WIDTH_MAX;
    end else begin
      eff_width = width_q;
    end
    eff_height = (height_q < bb3_pkg::HEIGHT_MIN) ? bb3_pkg::HEIGHT_MIN : height_q;
  end

  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_xfer    = in_valid_i && in_ready_o;
  assign in_pix     = {red_in_i, green_in_i, blue_in_i};

  always_comb begin
    col_cur  = frame_start_i ? '0 : col_q;
    row_cur  = frame_start_i ? '0 : row_q;
    col_last = (bb3_pkg::WIDTH_W'(col_cur) + bb3_pkg::WIDTH_W'(1)) >= eff_width;
    row_last = ((bb3_pkg::ROW_W + 1)'(row_cur) + (bb3_pkg::ROW_W + 1)'(1))
               >= (bb3_pkg::ROW_W + 1)'(eff_height);
    col_d    = col_q;
    row_d    = row_q;
    if (in_xfer) begin
      if (col_last) begin
        col_d = '0;
        row_d = row_last ? '0 : row_cur + bb3_pkg::ROW_W'(1);
      end else begin
        col_d = col_cur + bb3_pkg::COL_W'(1);
        row_d = row_cur;
      end
    end
    s1_pos_d.emit = (col_cur >= bb3_pkg::COL_W'(2)) && (row_cur >= bb3_pkg::ROW_W'(2));
    s1_pos_d.col  = col_cur - bb3_pkg::COL_W'(1);
    s1_pos_d.row  = row_cur - bb3_pkg::ROW_W'(1);
    s1_valid_d    = in_xfer ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= bb3_pkg::WIDTH_RESET;
      height_q   <= bb3_pkg::HEIGHT_RESET;
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      width_q    <= width_d;
      height_q   <= height_d;
      col_q      <= col_d;
      row_q      <= row_d;
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_pos_q  <= s1_pos_d;
      s1_cur_q  <= in_pix;
      s1_addr_q <= col_cur[bb3_pkg::ADDR_W-1:0];
    end
  end

  bb3_line_buf u_line_buf (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_xfer),
    .rd_addr_i (col_cur[bb3_pkg::ADDR_W-1:0]),
    .wr_en_i   (s1_adv),
    .wr_addr_i (s1_addr_q),
    .wr_data_i ({mid_pix, s1_cur_q}),
    .rd_data_o (rd_word)
  );

  assign top_pix = rd_word[2*bb3_pkg::NUM_CH*bb3_pkg::CHAN_W-1:bb3_pkg::NUM_CH*bb3_pkg::CHAN_W];
  assign mid_pix = rd_word[bb3_pkg::NUM_CH*bb3_pkg::CHAN_W-1:0];

  bb3_window u_window (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s1_valid_i (s1_valid_q),
    .s1_pos_i   (s1_pos_q),
    .top_i      (top_pix),
    .mid_i      (mid_pix),
    .cur_i      (s1_cur_q),
    .s3_ready_i (s2_ready),
    .adv_o      (s1_adv),
    .s2_valid_o (s2_valid),
    .s2_pos_o   (s2_pos),
    .s2_sums_o  (s2_sums)
  );

  bb3_div9 u_div9 (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s2_valid_i  (s2_valid),
    .s2_pos_i    (s2_pos),
    .s2_sums_i   (s2_sums),
    .s2_ready_o  (s2_ready),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_pix_o   (out_pix),
    .out_pos_o   (out_pos)
  );

  assign red_out_o       = out_pix[2];
  assign green_out_o     = out_pix[1];
  assign blue_out_o      = out_pix[0];
  assign center_column_o = out_pos.col;
  assign center_row_o    = out_pos.row;

endmodule

`default_nettype wire

[hw/rtl/bb3_line_buf.sv]
// Line store: one synchronous RAM holding the two previous rows side by side.
// Registered read with a bypass for a write to the same entry in the same cycle; uses bb3_pkg.
`default_nettype none

module bb3_line_buf (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             rd_en_i,
  input  logic [bb3_pkg::ADDR_W-1:0]       rd_addr_i,
  input  logic                             wr_en_i,
  input  logic [bb3_pkg::ADDR_W-1:0]       wr_addr_i,
  input  bb3_pkg::line_word_t              wr_data_i,
  output bb3_pkg::line_word_t              rd_data_o
);

  bb3_pkg::line_word_t mem [bb3_pkg::MAX_WIDTH];
  bb3_pkg::line_word_t mem_rd_q;
  bb3_pkg::line_word_t byp_data_q;
  logic                byp_hit_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      mem_rd_q   <= mem[rd_addr_i];
      byp_data_q <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_hit_q <= 1'b0;
    end else if (rd_en_i) begin
      byp_hit_q <= wr_en_i && (wr_addr_i == rd_addr_i);
    end
  end

  assign rd_data_o = byp_hit_q ? byp_data_q : mem_rd_q;

endmodule

`default_nettype wire

[hw/rtl/bb3_window.sv]
// Window stage: six window registers, the nine-tap channel sums and the sum register.
// Fed by the line store read and the pixel stage of the top level; uses bb3_pkg.
`default_nettype none

module bb3_window (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s1_valid_i,
  input  bb3_pkg::pos_t    s1_pos_i,
  input  bb3_pkg::pixel_t  top_i,
  input  bb3_pkg::pixel_t  mid_i,
  input  bb3_pkg::pixel_t  cur_i,
  input  logic             s3_ready_i,
  output logic             adv_o,
  output logic             s2_valid_o,
  output bb3_pkg::pos_t    s2_pos_o,
  output bb3_pkg::sums_t   s2_sums_o
);

  bb3_pkg::pixel_t win_q [6];
  bb3_pkg::pixel_t taps [bb3_pkg::NUM_TAPS];
  bb3_pkg::sums_t  sums_d;
  bb3_pkg::sums_t  sums_q;
  bb3_pkg::pos_t   pos_q;
  logic            s2_valid_q;
  logic            s2_valid_d;
  logic            s2_ready;

  always_comb begin
    taps[0] = win_q[0];
    taps[1] = win_q[1];
    taps[2] = top_i;
    taps[3] = win_q[2];
    taps[4] = win_q[3];
    taps[5] = mid_i;
    taps[6] = win_q[4];
    taps[7] = win_q[5];
    taps[8] = cur_i;
    for (int ch = 0; ch < bb3_pkg::NUM_CH; ch++) begin
      sums_d[ch] = '0;
      for (int k = 0; k < bb3_pkg::NUM_TAPS; k++) begin
        sums_d[ch] = sums_d[ch] + bb3_pkg::SUM_W'(taps[k][ch]);
      end
    end
  end

  assign s2_ready = !s2_valid_q || s3_ready_i;
  assign adv_o    = s1_valid_i && (!s1_pos_i.emit || s2_ready);

  always_comb begin
    s2_valid_d = s2_valid_q;
    if (adv_o && s1_pos_i.emit) begin
      s2_valid_d = 1'b1;
    end else if (s3_ready_i) begin
      s2_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= '0;
      end
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s2_valid_d;
      if (adv_o) begin
        win_q[0] <= win_q[1];
        win_q[1] <= top_i;
        win_q[2] <= win_q[3];
        win_q[3] <= mid_i;
        win_q[4] <= win_q[5];
        win_q[5] <= cur_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o && s1_pos_i.emit) begin
      sums_q <= sums_d;
      pos_q  <= s1_pos_i;
    end
  end

  assign s2_valid_o = s2_valid_q;
  assign s2_pos_o   = pos_q;
  assign s2_sums_o  = sums_q;

endmodule

`default_nettype wire

[hw/rtl/bb3_div9.sv]
// Divide-by-nine stage and output register of the box blur.
// Takes the channel sums from bb3_window; uses bb3_pkg.
`default_nettype none

module bb3_div9 (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s2_valid_i,
  input  bb3_pkg::pos_t    s2_pos_i,
  input  bb3_pkg::sums_t   s2_sums_i,
  output logic             s2_ready_o,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  output bb3_pkg::pixel_t  out_pix_o,
  output bb3_pkg::pos_t    out_pos_o
);

  logic [bb3_pkg::PROD_W-1:0] prod [bb3_pkg::NUM_CH];
  bb3_pkg::pixel_t            quot;
  bb3_pkg::pixel_t            pix_q;
  bb3_pkg::pos_t              pos_q;
  logic                       valid_q;
  logic                       s2_xfer;

  always_comb begin
    for (int ch = 0; ch < bb3_pkg::NUM_CH; ch++) begin
      prod[ch] = bb3_pkg::PROD_W'(s2_sums_i[ch]) * bb3_pkg::PROD_W'(bb3_pkg::RECIP9);
      quot[ch] = prod[ch][bb3_pkg::RECIP_SHIFT +: bb3_pkg::CHAN_W];
    end
  end

  assign s2_ready_o = !valid_q || out_ready_i;
  assign s2_xfer    = s2_valid_i && s2_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (s2_ready_o) begin
      valid_q <= s2_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_xfer) begin
      pix_q <= quot;
      pos_q <= s2_pos_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_pix_o   = pix_q;
  assign out_pos_o   = pos_q;

endmodule

`default_nettype wire

[hw/rtl/bb3_checker.sv]
// Port-level checker for the 3x3 box blur, bound to box_blur_3x3_rgb_unit.
// Sees the top-level ports only; uses bb3_pkg for widths.
`default_nettype none

module bb3_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_ready_o,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input logic [bb3_pkg::CHAN_W-1:0]     red_out_o,
  input logic [bb3_pkg::CHAN_W-1:0]     green_out_o,
  input logic [bb3_pkg::CHAN_W-1:0]     blue_out_o,
  input logic [bb3_pkg::COL_W-1:0]      center_column_o,
  input logic [bb3_pkg::ROW_W-1:0]      center_row_o
);

  // A result waiting for transfer stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result withdrawn before transfer");

  // A stalled result keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      $stable(red_out_o) && $stable(green_out_o) && $stable(blue_out_o) &&
      $stable(center_column_o) && $stable(center_row_o))
    else $error("stalled result changed");

  // With the output register empty the whole pipeline drains, so input is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output");

  // Reported positions are never in column 0, row 0 or the all-ones column.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (center_column_o != '0) && (center_row_o != '0) &&
      (center_column_o != '1))
    else $error("border position reported");

endmodule

bind box_blur_3x3_rgb_unit bb3_checker u_bb3_checker (.*);

`default_nettype wire

[bench/testbench.sv]
`timescale 1ns / 100ps
// Self-checking testbench for box_blur_3x3_rgb_unit: raster frames go in, and every filtered pixel
// that comes out is compared with a predicted 3x3 mean. Depends on bb3_pkg and the unit's RTL.

module testbench;
  import bb3_pkg::*;

  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 300;
  localparam int RANDOM_PIXELS = 760;
  localparam int MAX_REPORTS   = 10;

  typedef struct packed {
    pixel_t           px;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
  } blur_result_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  cfg_reg_e              cfg_idx_i     = CFG_IMAGE_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_wdata_i   = '0;
  logic                  in_valid_i    = 1'b0;
  logic                  in_ready_o;
  logic [CHAN_W-1:0]     red_in_i      = '0;
  logic [CHAN_W-1:0]     green_in_i    = '0;
  logic [CHAN_W-1:0]     blue_in_i     = '0;
  logic                  frame_start_i = 1'b0;
  logic                  out_valid_o;
  logic                  out_ready_i   = 1'b0;
  logic [CHAN_W-1:0]     red_out_o;
  logic [CHAN_W-1:0]     green_out_o;
  logic [CHAN_W-1:0]     blue_out_o;
  logic [COL_W-1:0]      center_column_o;
  logic [ROW_W-1:0]      center_row_o;

  pixel_t       older_row_mem [MAX_WIDTH];
  pixel_t       newer_row_mem [MAX_WIDTH];
  pixel_t       window_q [6];
  int           col_q    = 0;
  int           row_q    = 0;
  int           width_q  = 640;
  int           height_q = 480;
  blur_result_t blurred_q [$];

  int mismatches  = 0;
  int pixels_sent = 0;
  int cycle_count = 0;
  int stall_left  = 0;
  int hold_left   = 0;
  bit hold_req    = 1'b0;
  bit idle_on     = 1'b1;
  bit offering    = 1'b0;

  box_blur_3x3_rgb_unit DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .red_in_i        (red_in_i),
    .green_in_i      (green_in_i),
    .blue_in_i       (blue_in_i),
    .frame_start_i   (frame_start_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .red_out_o       (red_out_o),
    .green_out_o     (green_out_o),
    .blue_out_o      (blue_out_o),
    .center_column_o (center_column_o),
    .center_row_o    (center_row_o)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic void blur_pixel(pixel_t cur, logic fs);
    int           w;
    int           h;
    int           c;
    int           r;
    int           sum;
    pixel_t       top;
    pixel_t       mid;
    pixel_t       win [9];
    blur_result_t res;
    w = (width_q < 3) ? 3 : ((width_q > MAX_WIDTH) ? MAX_WIDTH : width_q);
    h = (height_q < 3) ? 3 : height_q;
    if (fs) begin
      col_q = 0;
      row_q = 0;
    end
    c = col_q;
    r = row_q;
    top = older_row_mem[c];
    mid = newer_row_mem[c];
    older_row_mem[c] = mid;
    newer_row_mem[c] = cur;
    win = '{window_q[0], window_q[1], top, window_q[2], window_q[3], mid,
            window_q[4], window_q[5], cur};
    if (c >= 2 && r >= 2) begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
        sum = 0;
        for (int k = 0; k < NUM_TAPS; k++) begin
          sum += win[k][ch];
        end
        res.px[ch] = CHAN_W'(sum / NUM_TAPS);
      end
      res.col = COL_W'(c - 1);
      res.row = ROW_W'(r - 1);
      blurred_q.push_back(res);
    end
    window_q = '{win[1], top, win[4], mid, win[7], cur};
    if (c + 1 >= w) begin
      col_q = 0;
      row_q = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      col_q = c + 1;
    end
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      if (mismatches < MAX_REPORTS) begin
        $display("Mismatch in %s: expected %0d, got %0d", name, want, got);
      end
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin : result_check
    blur_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (blurred_q.size() == 0) begin
        if (mismatches < MAX_REPORTS) begin
          $display("Unexpected result at column %0d, row %0d", center_column_o, center_row_o);
        end
        mismatches++;
      end else begin
        want = blurred_q.pop_front();
        check_field("red", want.px[2], red_out_o);
        check_field("green", want.px[1], green_out_o);
        check_field("blue", want.px[0], blue_out_o);
        check_field("column", want.col, center_column_o);
        check_field("row", want.row, center_row_o);
      end
    end
  end

  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 6);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  task automatic send_pixel(pixel_t px, logic fs);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      if (offering) begin
        in_valid_i <= 1'b0;
        offering = 1'b0;
      end
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    offering      = 1'b1;
    red_in_i      <= px[2];
    green_in_i    <= px[1];
    blue_in_i     <= px[0];
    frame_start_i <= fs;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    blur_pixel(px, fs);
    pixels_sent++;
  endtask

  task automatic send_random_pixels(int count, bit start_frame, int restart_odds);
    bit fs;
    for (int i = 0; i < count; i++) begin
      fs = (i == 0 && start_frame) ||
           (restart_odds > 0 && $urandom_range(1, restart_odds) == 1);
      send_pixel(pixel_t'($urandom), fs);
    end
  endtask

  task automatic wait_idle();
    if (offering) begin
      in_valid_i <= 1'b0;
      offering = 1'b0;
    end
    while (blurred_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_frame_size(int w_data, int h_data);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_IMAGE_WIDTH;
    cfg_wdata_i <= CFG_DATA_W'(w_data);
    @(posedge clk_i);
    width_q = w_data & ((1 << WIDTH_W) - 1);
    cfg_idx_i   <= CFG_IMAGE_HEIGHT;
    cfg_wdata_i <= CFG_DATA_W'(h_data);
    @(posedge clk_i);
    height_q = h_data & ((1 << HEIGHT_W) - 1);
    cfg_we_i <= 1'b0;
  endtask

  task automatic test_extreme_pixels();
    write_frame_size(3, 3);
    for (int i = 0; i < 9; i++) send_pixel('1, i == 0);
    for (int i = 0; i < 9; i++) send_pixel('0, 1'b0);
    for (int i = 0; i < 9; i++) begin
      send_pixel({8'(i * 31), 8'(255 - i), (i % 2 == 1) ? 8'hFF : 8'h00}, i == 0);
    end
  endtask

  task automatic test_size_clamping();
    write_frame_size(0, 1);
    send_random_pixels(18, 1'b1, 0);
    write_frame_size(2, 0);
    send_random_pixels(9, 1'b1, 0);
    write_frame_size(16'hF004, 2);
    send_random_pixels(24, 1'b1, 0);
  endtask

  task automatic test_frame_restart();
    write_frame_size(5, 4);
    send_random_pixels(13, 1'b1, 0);
    send_random_pixels(20, 1'b1, 0);
    send_random_pixels(3, 1'b1, 0);
    send_random_pixels(20, 1'b1, 0);
    send_random_pixels(20, 1'b1, 0);
  endtask

  task automatic test_shrink_mid_frame();
    write_frame_size(8, 10);
    send_random_pixels(30, 1'b1, 0);
    write_frame_size(4, 10);
    send_random_pixels(7, 1'b0, 0);
    write_frame_size(4, 4);
    send_random_pixels(48, 1'b0, 0);
  endtask

  task automatic test_output_hold_off();
    write_frame_size(16, 8);
    hold_req = 1'b1;
    send_random_pixels(400, 1'b1, 0);
    wait_idle();
    send_random_pixels(100, 1'b0, 0);
  endtask

  task automatic test_random_frames();
    int target;
    int sel;
    int w;
    int h;
    int rows;
    int count;
    target = pixels_sent + RANDOM_PIXELS;
    while (pixels_sent < target) begin
      idle_on = (pixels_sent < target - 300) && ($urandom_range(0, 3) != 0);
      sel = $urandom_range(0, 19);
      if (sel < 14) w = $urandom_range(3, 12);
      else if (sel < 18) w = $urandom_range(13, 64);
      else w = $urandom_range(0, 2);
      sel = $urandom_range(0, 19);
      if (sel < 14) h = $urandom_range(3, 8);
      else if (sel < 17) h = $urandom_range(0, 2);
      else h = $urandom_range(9, 65535);
      rows = (h < 3) ? 3 : ((h > 8) ? $urandom_range(3, 8) : h);
      count = ((w < 3) ? 3 : w) * rows * $urandom_range(1, 3);
      if ($urandom_range(0, 3) == 0) count += $urandom_range(1, 2 * ((w < 3) ? 3 : w));
      if (count > 400) count = 400;
      if (pixels_sent < target - 300 && count > target - 300 - pixels_sent) begin
        count = target - 300 - pixels_sent;
      end
      if (count > target - pixels_sent) count = target - pixels_sent;
      write_frame_size(($urandom_range(0, 15) << WIDTH_W) | w, h);
      send_random_pixels(count, 1'b1, ($urandom_range(0, 4) == 0) ? 30 : 0);
    end
  endtask

  initial begin
    for (int i = 0; i < MAX_WIDTH; i++) begin
      older_row_mem[i] = '0;
      newer_row_mem[i] = '0;
    end
    for (int i = 0; i < 6; i++) window_q[i] = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extreme_pixels();
    test_size_clamping();
    test_frame_restart();
    test_shrink_mid_frame();
    test_output_hold_off();
    test_random_frames();
    wait_idle();
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
